>>> rtl/point_box_min_distance_defines.svh
// Assertion macros for the point-to-box distance block.
// Included by the checker; no other dependencies.
`ifndef POINT_BOX_MIN_DISTANCE_DEFINES_SVH
`define POINT_BOX_MIN_DISTANCE_DEFINES_SVH

// Plain property, checked out of reset.
`define PBMD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle, checked out of reset.
`define PBMD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, checked out of reset.
`define PBMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pbmd_pkg.sv
// Shared constants and types for the point-to-box distance block.
// No dependencies.
`default_nettype none

package pbmd_pkg;

  localparam int DIMS_DEF       = 2;
  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_BITS       = 25;
  localparam int FRAC_BITS      = 8;
  localparam int NUM_COORDS     = 6;
  localparam int OUT_DW         = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  // Control and side data that travels with the sum of squares.
  typedef struct packed {
    logic                vld;
    logic                euclid;
    logic [OUT_BITS-1:0] man_q8;
  } pbmd_side_t;

endpackage

`default_nettype wire

>>> rtl/pbmd_lane.sv
// One axis lane: gap from point to the nearer box face, then its square.
// Depends on pbmd_pkg for parameter defaults.
`default_nettype none

module pbmd_lane
  import pbmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [COORD_BITS-1:0]     pt,
  input  wire logic [COORD_BITS-1:0]     lo,
  input  wire logic [COORD_BITS-1:0]     hi,
  output logic      [COORD_BITS:0]       gap_o,
  output logic      [2*COORD_BITS+1:0]   sq_o
);

  localparam int GW  = COORD_BITS + 1;
  localparam int SQW = 2 * GW;

  logic [GW-1:0]  pt_x, lo_x, hi_x;
  logic [GW-1:0]  gap_nxt, gap_r, gapd_r;
  logic [SQW-1:0] sq_nxt, sq_r;

  assign pt_x = {pt[COORD_BITS-1], pt};
  assign lo_x = {lo[COORD_BITS-1], lo};
  assign hi_x = {hi[COORD_BITS-1], hi};

  // Below test first, so an inverted box still picks lo - p.
  always_comb begin
    if ($signed(pt) < $signed(lo)) begin
      gap_nxt = lo_x - pt_x;
    end else if ($signed(pt) > $signed(hi)) begin
      gap_nxt = pt_x - hi_x;
    end else begin
      gap_nxt = '0;
    end
  end

  assign sq_nxt = SQW'(gap_r) * SQW'(gap_r);

  always_ff @(posedge clk) begin
    if (en) begin
      gap_r  <= gap_nxt;
      sq_r   <= sq_nxt;
      gapd_r <= gap_r;
    end
  end

  assign gap_o = gapd_r;
  assign sq_o  = sq_r;

endmodule

`default_nettype wire

>>> rtl/pbmd_merge.sv
// Merge stage: sums lane squares and lane gaps, scales and clamps the
// Manhattan result. Depends on pbmd_pkg.
`default_nettype none

module pbmd_merge
  import pbmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int NL         = DIMS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                vld_i,
  input  wire logic                                euclid_i,
  input  wire logic [NL-1:0][COORD_BITS:0]         gap_i,
  input  wire logic [NL-1:0][2*COORD_BITS+1:0]     sq_i,
  output logic      [2*COORD_BITS+2:0]             sum_o,
  output pbmd_side_t                               side_o
);

  localparam int GW   = COORD_BITS + 1;
  localparam int SQW  = 2 * GW;
  localparam int SUMW = SQW + 1;
  localparam int MANW = GW + 1;
  localparam int SHW  = MANW + FRAC_BITS;
  localparam int MEW  = (SHW > OUT_BITS) ? SHW : OUT_BITS;

  logic [SUMW-1:0]     sum_nxt, sum_r;
  logic [MANW-1:0]     man;
  logic [MEW-1:0]      man_ext;
  logic [OUT_BITS-1:0] man_nxt, man_r;
  logic                vld_r, euc_r;

  always_comb begin
    sum_nxt = '0;
    man     = '0;
    for (int i = 0; i < NL; i++) begin
      sum_nxt = sum_nxt + SUMW'(sq_i[i]);
      man     = man + MANW'(gap_i[i]);
    end
    man_ext = MEW'({man, {FRAC_BITS{1'b0}}});
    if (man_ext > MEW'(OUT_MAX)) begin
      man_nxt = OUT_MAX;
    end else begin
      man_nxt = OUT_BITS'(man_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      euc_r <= euclid_i;
      sum_r <= sum_nxt;
      man_r <= man_nxt;
    end
  end

  assign sum_o         = sum_r;
  assign side_o.vld    = vld_r;
  assign side_o.euclid = euc_r;
  assign side_o.man_q8 = man_r;

endmodule

`default_nettype wire

>>> rtl/pbmd_root.sv
// Pipelined square root, one root bit per stage, with 8 fractional bits,
// rounded down; picks the Manhattan or Euclidean result. Depends on pbmd_pkg.
`default_nettype none

module pbmd_root
  import pbmd_pkg::*;
#(
  parameter int IN_W = 2 * (COORD_BITS_DEF + 1) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [IN_W-1:0]     rad_i,
  input  pbmd_side_t               side_i,
  output logic      [OUT_BITS-1:0] dist_o,
  output logic                     vld_o
);

  localparam int RAW = IN_W + 2 * FRAC_BITS;
  localparam int RB  = (RAW + 1) / 2;
  localparam int RW  = 2 * RB;
  localparam int EW  = (RB > OUT_BITS) ? RB : OUT_BITS;

  logic [RW-1:0]   rad_r  [RB];
  logic [RB+1:0]   rem_r  [RB];
  logic [RB-1:0]   root_r [RB];
  pbmd_side_t      side_r [RB];

  logic [EW-1:0]       root_ext;
  logic [OUT_BITS-1:0] root_sat, res_nxt, res_r;
  logic                res_vld_r;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RW-1:0]  rad_in, rad_nxt;
    logic [RB-1:0]  rem_in;
    logic [RB-1:0]  root_in, root_nxt;
    logic [RB+1:0]  rem_sh, trial, rem_nxt;
    pbmd_side_t     side_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = RW'({rad_i, {(2 * FRAC_BITS){1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1][RB-1:0];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down the next radicand bit pair and try root*4+1.
    assign rem_sh   = {rem_in, rad_in[RW-1:RW-2]};
    assign trial    = {root_in, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_in[RB-2:0], ge};
    assign rad_nxt  = {rad_in[RW-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k].vld <= side_in.vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k].euclid <= side_in.euclid;
        side_r[k].man_q8 <= side_in.man_q8;
        rad_r[k]         <= rad_nxt;
        rem_r[k]         <= rem_nxt;
        root_r[k]        <= root_nxt;
      end
    end
  end

  always_comb begin
    root_ext = EW'(root_r[RB-1]);
    if (root_ext > EW'(OUT_MAX)) begin
      root_sat = OUT_MAX;
    end else begin
      root_sat = OUT_BITS'(root_ext);
    end
    res_nxt = side_r[RB-1].euclid ? root_sat : side_r[RB-1].man_q8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (en) begin
      res_vld_r <= side_r[RB-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign dist_o = res_r;
  assign vld_o  = res_vld_r;

endmodule

`default_nettype wire

>>> rtl/point_box_min_distance.sv
// Two lane stages (gap, square), one merge stage, one square-root stage per
// root bit and one output register. Throughput: one word per cycle; the whole
// pipeline holds while the output word waits, so in_tready follows
// (!out_tvalid || out_tready). Reset: synchronous, active low, clears the
// valid bits of every stage; no state beyond the pipeline.
`default_nettype none

module point_box_min_distance
  import pbmd_pkg::*;
#(
  parameter int DIMS       = DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // point_x, point_y, box_lo_x, box_lo_y, box_hi_x, box_hi_y, zero pad
  input  wire logic [((NUM_COORDS*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // use_euclid
  input  wire logic [0:0]                                 in_tuser,
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // distance_q8, zero pad
  output logic      [OUT_DW-1:0]                          out_tdata
);

  localparam int NL   = (DIMS < 2) ? DIMS : 2;
  localparam int GW   = COORD_BITS + 1;
  localparam int SQW  = 2 * GW;
  localparam int SUMW = SQW + 1;

  logic                      adv;
  logic                      va_r, vb_r, ea_r, eb_r;
  logic [NL-1:0][GW-1:0]     gap;
  logic [NL-1:0][SQW-1:0]    sq;
  logic [SUMW-1:0]           sum;
  pbmd_side_t                side;
  logic [OUT_BITS-1:0]       dist_q8;
  logic                      dist_vld;

  // Advance every stage unless the output word is stalled.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    pbmd_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (adv),
      .pt   (in_tdata[i*COORD_BITS +: COORD_BITS]),
      .lo   (in_tdata[(2+i)*COORD_BITS +: COORD_BITS]),
      .hi   (in_tdata[(4+i)*COORD_BITS +: COORD_BITS]),
      .gap_o(gap[i]),
      .sq_o (sq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ea_r <= in_tuser[0];
      eb_r <= ea_r;
    end
  end

  pbmd_merge #(
    .COORD_BITS(COORD_BITS),
    .NL        (NL)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_i   (vb_r),
    .euclid_i(eb_r),
    .gap_i   (gap),
    .sq_i    (sq),
    .sum_o   (sum),
    .side_o  (side)
  );

  pbmd_root #(
    .IN_W(SUMW)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .rad_i (sum),
    .side_i(side),
    .dist_o(dist_q8),
    .vld_o (dist_vld)
  );

  assign out_tvalid = dist_vld;
  assign out_tdata  = OUT_DW'(dist_q8);

endmodule

`default_nettype wire

>>> rtl/pbmd_chk.sv
// Port-level checker for point_box_min_distance, bound to the top level.
// Depends on pbmd_pkg and point_box_min_distance_defines.svh.
`default_nettype none

`include "point_box_min_distance_defines.svh"

module pbmd_chk
  import pbmd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata
);

  `PBMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")

  `PBMD_ASSERT(a_ready_follows, clk, rst_n, in_tready == (!out_tvalid || out_tready), "input ready does not follow output stall")

  `PBMD_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_DW-1:OUT_BITS] == '0, "output pad bits not zero")

endmodule

bind point_box_min_distance pbmd_chk u_pbmd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

>>> sim/pbmd_distance_check.sv
`timescale 1ns / 1ps
// Watches both streams of point_box_min_distance, predicts each distance word and compares.
// Depends on pbmd_pkg; instantiated beside the block by point_box_min_distance_test.
module pbmd_distance_check
  import pbmd_pkg::*;
#(
  parameter int IN_DW = ((NUM_COORDS * COORD_BITS_DEF + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  // point_x, point_y, box_lo_x, box_lo_y, box_hi_x, box_hi_y
  input  wire logic [IN_DW-1:0] in_tdata,
  // use_euclid
  input  wire logic [0:0]       in_tuser,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  // distance_q8, zero pad
  input  wire logic [OUT_DW-1:0] out_tdata,
  output int                    fail_count,
  output int                    distances_owed
);

  // point_x sits in the lowest bits, so it is declared last
  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] box_hi_y;
    logic signed [COORD_BITS_DEF-1:0] box_hi_x;
    logic signed [COORD_BITS_DEF-1:0] box_lo_y;
    logic signed [COORD_BITS_DEF-1:0] box_lo_x;
    logic signed [COORD_BITS_DEF-1:0] point_y;
    logic signed [COORD_BITS_DEF-1:0] point_x;
  } box_query_t;

  logic [OUT_DW-1:0] pending_distance[$];

  // Below test first, so an inverted box still yields lo - p for a point under lo.
  function automatic logic [63:0] axis_gap(logic signed [COORD_BITS_DEF-1:0] p,
                                           logic signed [COORD_BITS_DEF-1:0] lo,
                                           logic signed [COORD_BITS_DEF-1:0] hi);
    if (p < lo) return 64'(int'(lo) - int'(p));
    if (p > hi) return 64'(int'(p) - int'(hi));
    return '0;
  endfunction

  function automatic logic [OUT_BITS-1:0] min_distance_q8(box_query_t q, logic euclid);
    logic [63:0] gx;
    logic [63:0] gy;
    logic [63:0] acc;
    logic [63:0] root;
    logic [63:0] trial;
    gx = axis_gap(q.point_x, q.box_lo_x, q.box_hi_x);
    gy = axis_gap(q.point_y, q.box_lo_y, q.box_hi_y);
    if (euclid) begin
      acc = (gx * gx + gy * gy) << (2 * FRAC_BITS);
      root = '0;
      // floor of the square root, one bit at a time
      for (int b = 27; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= acc) root = trial;
      end
      acc = root;
    end else begin
      acc = (gx + gy) << FRAC_BITS;
    end
    if (acc > OUT_MAX) return OUT_MAX;
    return acc[OUT_BITS-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [OUT_DW-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_distance.size() == 0) begin
          if (fail_count < 10) $display("unexpected distance word %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_distance.pop_front();
          if (out_tdata !== want) begin
            if (fail_count < 10)
              $display("distance mismatch: expected %h, got %h", want, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_distance.push_back(OUT_DW'(min_distance_q8(box_query_t'(in_tdata), in_tuser[0])));
      distances_owed = pending_distance.size();
    end
  end

endmodule

>>> sim/point_box_min_distance_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for point_box_min_distance: directed corners, then bursty random queries.
// Depends on pbmd_pkg, the RTL and pbmd_distance_check, which predicts and compares.
module point_box_min_distance_test;
  import pbmd_pkg::*;

  localparam int IN_DW          = ((NUM_COORDS * COORD_BITS_DEF + 7) / 8) * 8;
  localparam int RANDOM_QUERIES = 600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [15:0] C_MIN = 16'h8000;
  localparam logic [15:0] C_MAX = 16'h7FFF;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_CHOKE, RX_COMB} rx_mode_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata   = '0;
  logic [0:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  int          fail_count;
  int          distances_owed;
  int unsigned cycle_count = 0;
  rx_mode_t    rx_mode     = RX_FREE;
  int          rx_left     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_box_min_distance DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pbmd_distance_check #(.IN_DW(IN_DW)) checker_0 (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .distances_owed(distances_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver backpressure: switch between free flow, coin flips, long chokes and a comb.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_tready <= ($urandom_range(0, 7) == 0);
      default:  out_tready <= (cycle_count[3:0] < 4'd11);
    endcase
  end

  // Present one word and hold it until accepted; returns at the accepting edge.
  task automatic send_query(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] lox, input logic [15:0] loy,
                            input logic [15:0] hix, input logic [15:0] hiy,
                            input logic euclid);
    in_tvalid   <= 1'b1;
    in_tdata    <= {hiy, hix, loy, lox, py, px};
    in_tuser[0] <= euclid;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    in_tvalid <= 1'b0;
    in_tdata  <= {$urandom, $urandom, $urandom};
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'h8001;
    endcase
  endfunction

  // Mostly ordered boxes with the point inside, outside or on a face; some noise and inverted boxes.
  task automatic draw_axis(output logic [15:0] p, output logic [15:0] lo, output logic [15:0] hi);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] t;
    int          span;
    a = 16'($urandom);
    b = 16'($urandom);
    p = 16'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        lo = a;
        hi = b;
      end
      1: begin
        p  = pick_extreme();
        lo = pick_extreme();
        hi = pick_extreme();
      end
      2: begin
        p  = 16'($urandom_range(0, 64)) - 16'd32;
        lo = 16'($urandom_range(0, 64)) - 16'd32;
        hi = 16'($urandom_range(0, 64)) - 16'd32;
      end
      default: begin
        if ($signed(a) > $signed(b)) begin
          t = a;
          a = b;
          b = t;
        end
        if ($urandom_range(0, 9) == 0) b = a;
        lo   = a;
        hi   = b;
        span = int'($signed(b)) - int'($signed(a));
        case ($urandom_range(0, 3))
          0:       p = a + 16'($urandom_range(0, span));
          1:       p = ($urandom_range(0, 1) != 0) ? a : b;
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic send_random();
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] lox;
    logic [15:0] loy;
    logic [15:0] hix;
    logic [15:0] hiy;
    draw_axis(px, lox, hix);
    draw_axis(py, loy, hiy);
    send_query(px, py, lox, loy, hix, hiy, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_query(16'd0, 16'd0, -16'sd5, -16'sd5, 16'd5, 16'd5, 1'b0);
    send_query(16'd0, 16'd0, -16'sd5, -16'sd5, 16'd5, 16'd5, 1'b1);
    // widest gaps on both axes, point below and then above
    send_query(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
    send_query(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
    send_query(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
    send_query(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    send_query(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);
    send_query(C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    // point on the faces, then points below an ordered box
    send_query(-16'sd5, 16'd5, -16'sd5, -16'sd5, 16'd5, 16'd5, 1'b1);
    send_query(-16'sd5, 16'd5, -16'sd5, -16'sd5, 16'd5, 16'd5, 1'b0);
    send_query(16'd0, 16'd0, 16'd3, 16'd4, 16'd10, 16'd10, 1'b1);
    send_query(16'd0, 16'd0, 16'd3, 16'd4, 16'd10, 16'd10, 1'b0);
    send_query(16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd2, 1'b1);
    // inverted boxes: below, above and between the swapped bounds; then two ordered boxes
    send_query(16'd0, 16'd0, 16'd10, 16'd0, -16'sd10, 16'd0, 1'b0);
    send_query(16'd20, 16'd0, 16'd10, 16'd0, -16'sd10, 16'd0, 1'b1);
    send_query(-16'sd20, 16'd0, 16'd10, 16'd0, -16'sd10, 16'd0, 1'b0);
    send_query(16'd0, 16'd5, 16'd0, 16'd10, 16'd0, -16'sd10, 1'b1);
    send_query(16'd3, 16'd100, 16'd0, 16'd0, 16'd5, 16'd5, 1'b0);
    send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    sent = 0;
    while (sent < RANDOM_QUERIES) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (distances_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
